FILE: src/hyperedge_partition_pin_counter_defines.svh
// ----------------------------------------------------------------------------
// hyperedge_partition_pin_counter_defines
// Assertion macros used by the pin counter top level.
// ----------------------------------------------------------------------------
`ifndef HYPEREDGE_PARTITION_PIN_COUNTER_DEFINES_SVH
`define HYPEREDGE_PARTITION_PIN_COUNTER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define HPPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HPPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/hppc_pkg.sv
// ----------------------------------------------------------------------------
// hppc_pkg
// Shared types and constants of the hyperedge partition pin counter.
// ----------------------------------------------------------------------------
package hppc_pkg;

  localparam int HEDGE_W = 10;
  localparam int PART_W  = 6;
  localparam int PHC_W   = 11;
  localparam logic [PHC_W-1:0] PHC_MAX = {PHC_W{1'b1}};

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic update;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

FILE: src/hyperedge_partition_pin_counter.sv
// ----------------------------------------------------------------------------
// hyperedge_partition_pin_counter
// Per (hyperedge, partition) pin counts with per-partition occupancy counts.
// A request is read from the tables, then updated once the output is free; one in flight at a time.
// Reset: clearing pass over all MAX_HEDGES * PARTITIONS pairs (65536 default), in_tready low.
// ----------------------------------------------------------------------------
`include "hyperedge_partition_pin_counter_defines.svh"

module hyperedge_partition_pin_counter
  import hppc_pkg::*;
#(
  parameter int MAX_HEDGES = 1024,
  parameter int PARTITIONS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [9:0] hedge_index, [15:10] partition
  input  logic [15:0] in_tdata,
  // [0] operation
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // pin_count, partition_hedge_count, occupancy_changed, error, zero fill
  output logic [((COUNT_BITS + PHC_W + 2 + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W = ((COUNT_BITS + PHC_W + 2 + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  hppc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  hppc_dp #(
    .MAX_HEDGES (MAX_HEDGES),
    .PARTITIONS (PARTITIONS),
    .COUNT_BITS (COUNT_BITS),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tuser),
    .in_hedge  (in_tdata[HEDGE_W-1:0]),
    .in_part   (in_tdata[HEDGE_W+PART_W-1:HEDGE_W]),
    .out_tdata (out_tdata)
  );

  // one request in flight at a time
  `HPPC_ASSERT(a_one_in_flight, (in_tvalid && in_tready) |=> !in_tready, "request during update")
  // with the output free, a result follows accept through ST_CALC and the result register
  `HPPC_ASSERT(a_latency, (in_tvalid && in_tready && !out_tvalid) |-> ##2 out_tvalid, "no result")
  // nothing is accepted while reset is held
  `HPPC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !in_tready && !out_tvalid, "busy in reset")

endmodule

FILE: src/hppc_ram.sv
// ----------------------------------------------------------------------------
// hppc_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hppc_ram #(
  parameter int     WIDTH = 16,
  parameter longint DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/hppc_ctrl.sv
// ----------------------------------------------------------------------------
// hppc_ctrl
// Sequencer: clearing pass after reset, then read / update per request.
// ----------------------------------------------------------------------------
module hppc_ctrl
  import hppc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CALC: cmd.update = out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: src/hppc_dp.sv
// ----------------------------------------------------------------------------
// hppc_dp
// Datapath: pair count and partition count tables, update logic, result reg.
// ----------------------------------------------------------------------------
module hppc_dp
  import hppc_pkg::*;
#(
  parameter int MAX_HEDGES = 1024,
  parameter int PARTITIONS = 64,
  parameter int COUNT_BITS = 16,
  parameter int OUT_W      = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               in_op,
  input  logic [HEDGE_W-1:0] in_hedge,
  input  logic [PART_W-1:0]  in_part,
  output logic [OUT_W-1:0]   out_tdata
);

  localparam longint DEPTH  = longint'(MAX_HEDGES) * longint'(PARTITIONS);
  localparam int     ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int     PW     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam logic [COUNT_BITS-1:0] PIN_MAX = {COUNT_BITS{1'b1}};
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // request latched at accept
  logic              op_r;
  logic [ADDR_W-1:0] slot_r;
  logic [PW-1:0]     part_r;
  logic              ok_r;

  logic              in_ok;
  logic [ADDR_W-1:0] in_slot;

  logic [COUNT_BITS-1:0] cnt_rd, cnt_new;
  logic [PHC_W-1:0]      phc_rd, phc_new;
  logic                  chg, err;

  logic                  pin_we, part_we;
  logic [ADDR_W-1:0]     pin_waddr;
  logic [COUNT_BITS-1:0] pin_wdata;
  logic [PW-1:0]         part_waddr;
  logic [PHC_W-1:0]      part_wdata;

  logic [COUNT_BITS-1:0] pin_r;
  logic [PHC_W-1:0]      phc_r;
  logic                  chg_r, err_r;

  assign in_ok   = (32'(in_hedge) < 32'(MAX_HEDGES)) && (32'(in_part) < 32'(PARTITIONS));
  assign in_slot = ADDR_W'(64'(in_hedge) * 64'(PARTITIONS) + 64'(in_part));

  // clearing sweep
  assign clr_cnt_nxt  = cmd.clr_en ? clr_cnt_r + ADDR_W'(1) : clr_cnt_r;
  assign sts.clr_last = (clr_cnt_r == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      slot_r <= in_slot;
      part_r <= PW'(in_part);
      ok_r   <= in_ok;
    end
  end

  // saturating read-modify-write
  always_comb begin
    cnt_new = cnt_rd;
    phc_new = phc_rd;
    chg     = 1'b0;
    err     = 1'b0;
    if (op_r == OP_ADD) begin
      if (cnt_rd == PIN_MAX) begin
        err = 1'b1;
      end else begin
        cnt_new = cnt_rd + COUNT_BITS'(1);
        if (cnt_rd == '0) begin
          chg = 1'b1;
          if (phc_rd != PHC_MAX) phc_new = phc_rd + PHC_W'(1);
        end
      end
    end else begin
      if (cnt_rd == '0) begin
        err = 1'b1;
      end else begin
        cnt_new = cnt_rd - COUNT_BITS'(1);
        if (cnt_rd == COUNT_BITS'(1)) begin
          chg = 1'b1;
          if (phc_rd != '0) phc_new = phc_rd - PHC_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (cmd.clr_en) begin
      pin_we     = 1'b1;
      pin_waddr  = clr_cnt_r;
      pin_wdata  = '0;
      part_we    = 1'b1;
      part_waddr = clr_cnt_r[PW-1:0];
      part_wdata = '0;
    end else begin
      pin_we     = cmd.update && ok_r && !err;
      pin_waddr  = slot_r;
      pin_wdata  = cnt_new;
      part_we    = cmd.update && ok_r && chg;
      part_waddr = part_r;
      part_wdata = phc_new;
    end
  end

  hppc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_pin_ram (
    .clk   (clk),
    .we    (pin_we),
    .waddr (pin_waddr),
    .wdata (pin_wdata),
    .re    (cmd.load),
    .raddr (in_slot),
    .rdata (cnt_rd)
  );

  hppc_ram #(
    .WIDTH (PHC_W),
    .DEPTH (longint'(PARTITIONS))
  ) u_part_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata (part_wdata),
    .re    (cmd.load),
    .raddr (PW'(in_part)),
    .rdata (phc_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (ok_r) begin
        pin_r <= cnt_new;
        phc_r <= phc_new;
        chg_r <= chg;
        err_r <= err;
      end else begin
        pin_r <= '0;
        phc_r <= '0;
        chg_r <= 1'b0;
        err_r <= 1'b1;
      end
    end
  end

  assign out_tdata = OUT_W'({err_r, chg_r, phc_r, pin_r});

endmodule

FILE: bench/hyperedge_partition_pin_counter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hyperedge_partition_pin_counter_test
// Streams add and remove-pin requests into the pin counter and keeps its own
// copy of the pair and partition occupancy tables to predict every update.
// Covers the field extremes, remove at zero, and random traffic focused on a
// few hot pairs under stall and backpressure.
// ----------------------------------------------------------------------------
module hyperedge_partition_pin_counter_test
  import hppc_pkg::*;
();

  localparam int CNT_W = 16;
  localparam int OUT_W = ((CNT_W + PHC_W + 2 + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] PIN_MAX = {CNT_W{1'b1}};
  localparam int WATCHDOG_LIMIT = 250000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic             err;
    logic             occ;
    logic [PHC_W-1:0] phc;
    logic [CNT_W-1:0] pin;
  } pin_update_t;

  // Predicts one update per request and checks them in order.
  class pin_ledger;
    bit [CNT_W-1:0] pair_cnt [0:65535];   // index {hedge, partition}
    bit [PHC_W-1:0] part_hedges [0:63];
    pin_update_t    want_q [$];
    int             failures;

    function int pending();
      return want_q.size();
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    function void apply_request(logic op, logic [HEDGE_W-1:0] hedge,
                                logic [PART_W-1:0] part);
      pin_update_t u;
      u.pin = pair_cnt[{hedge, part}];
      u.phc = part_hedges[part];
      u.occ = 1'b0;
      u.err = 1'b0;
      if (op == OP_ADD) begin
        if (u.pin == PIN_MAX) begin
          u.err = 1'b1;
        end else begin
          if (u.pin == '0) begin
            u.occ = 1'b1;
            if (u.phc != PHC_MAX) u.phc = u.phc + PHC_W'(1);
          end
          u.pin = u.pin + CNT_W'(1);
        end
      end else begin
        if (u.pin == '0) begin
          u.err = 1'b1;
        end else begin
          u.pin = u.pin - CNT_W'(1);
          if (u.pin == '0) begin
            u.occ = 1'b1;
            if (u.phc != '0) u.phc = u.phc - PHC_W'(1);
          end
        end
      end
      pair_cnt[{hedge, part}] = u.pin;
      part_hedges[part] = u.phc;
      want_q.push_back(u);
    endfunction

    function void check_update(logic [OUT_W-1:0] word);
      pin_update_t want, got;
      if (want_q.size() == 0) begin
        flag("unexpected update", '0, 32'(word));
        return;
      end
      want = want_q.pop_front();
      got = word[$bits(pin_update_t)-1:0];
      if (got.pin !== want.pin) flag("pin_count", 32'(want.pin), 32'(got.pin));
      if (got.phc !== want.phc) flag("partition_hedge_count", 32'(want.phc), 32'(got.phc));
      if (got.occ !== want.occ) flag("occupancy_changed", 32'(want.occ), 32'(got.occ));
      if (got.err !== want.err) flag("error", 32'(want.err), 32'(got.err));
      if (word[OUT_W-1:$bits(pin_update_t)] !== '0)
        flag("fill bits", '0, 32'(word[OUT_W-1:$bits(pin_update_t)]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = OP_ADD;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  pin_ledger ledger = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int stall_cycles = 0;

  hyperedge_partition_pin_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: check, then pick tready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) ledger.check_update(out_tdata);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_pin(input logic op, input logic [HEDGE_W-1:0] hedge,
                          input logic [PART_W-1:0] part);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {part, hedge};
    do @(posedge clk); while (!in_tready);
    ledger.apply_request(op, hedge, part);
  endtask

  task automatic drain_updates();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Mostly a few hot pairs so counts walk across zero; the rest is spread.
  task automatic run_random(input int n, input int hold_at, input int pause_at);
    logic [HEDGE_W-1:0] hedge_pool [8];
    logic [PART_W-1:0]  part_pool [4];
    logic op;
    logic [HEDGE_W-1:0] hedge;
    logic [PART_W-1:0] part;
    foreach (hedge_pool[i]) hedge_pool[i] = HEDGE_W'($urandom_range(0, 1023));
    foreach (part_pool[i]) part_pool[i] = PART_W'($urandom_range(0, 63));
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) rx_hold_req = LONG_HOLD;
      if (i == pause_at) drain_updates();
      if ($urandom_range(0, 99) < 75) begin
        hedge = hedge_pool[3'($urandom_range(0, 7))];
        part  = part_pool[2'($urandom_range(0, 3))];
        op    = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_REMOVE;
      end else begin
        hedge = HEDGE_W'($urandom_range(0, 1023));
        part  = PART_W'($urandom_range(0, 63));
        op    = $urandom_range(0, 1) ? OP_REMOVE : OP_ADD;
      end
      send_pin(op, hedge, part);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_pin(OP_REMOVE, 10'd0, 6'd0);       // remove at zero
    send_pin(OP_ADD, 10'd0, 6'd0);
    send_pin(OP_ADD, 10'd0, 6'd0);
    send_pin(OP_ADD, 10'd1023, 6'd63);
    send_pin(OP_ADD, 10'd1023, 6'd0);
    send_pin(OP_ADD, 10'd0, 6'd63);
    send_pin(OP_ADD, 10'h2AA, 6'h15);
    send_pin(OP_ADD, 10'h155, 6'h2A);
    send_pin(OP_ADD, 10'h155, 6'h15);
    send_pin(OP_REMOVE, 10'd0, 6'd0);
    send_pin(OP_REMOVE, 10'd0, 6'd0);
    send_pin(OP_REMOVE, 10'd0, 6'd0);
    send_pin(OP_REMOVE, 10'd1023, 6'd63);
    send_pin(OP_REMOVE, 10'd1023, 6'd63);
    send_pin(OP_REMOVE, 10'h2AA, 6'h15);
    send_pin(OP_ADD, 10'h2AA, 6'h15);

    send_pin(OP_REMOVE, 10'd512, 6'd31);
    send_pin(OP_ADD, 10'd512, 6'd31);
    drain_updates();

    tx_idle_pct = 28;
    rx_idle_pct = 88;
    run_random(630, 200, -1);
    drain_updates();

    tx_idle_pct = 88;
    rx_idle_pct = 28;
    run_random(630, -1, 300);
    drain_updates();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(640, 400, 100);
    drain_updates();
    repeat (20) @(posedge clk);

    if (ledger.failures == 0 && ledger.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/hppc_pkg.sv
src/hppc_ram.sv
src/hppc_ctrl.sv
src/hppc_dp.sv
src/hyperedge_partition_pin_counter.sv
bench/hyperedge_partition_pin_counter_test.sv
